// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file bba_checker.sv.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at each rising clock edge outside reset
`define CHK_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Consequent checked a fixed number of cycles after the antecedent
`define CHK_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("delayed check failed");

`endif

// ===== design/bba_pkg.sv =====
// Package for the bitmap block allocator: field widths, defaults and codes.
// No dependencies; imported by the top level, its checker and the testbench.
`default_nettype none

package bba_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int INIT_RESET    = 16;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC_NAMED = 2'd0,
        FN_ALLOC_FIRST = 2'd1,
        FN_FREE_NAMED  = 2'd2,
        FN_FREE_LOWEST = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_RANGE  = 3'd1,
        ST_INUSE  = 3'd2,
        ST_NOFREE = 3'd3,
        ST_NONE   = 3'd4
    } status_t;

endpackage

`default_nettype wire

// ===== design/bitmap_block_allocator_unit.sv =====
// The strobe done follows an accepted item through s0_v_reg, s1_v_reg, s2_v_reg to done_reg.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Stage 1 applies the operation to the bitmap; stages 2 and 3 find the longest used run.
// Reset (rst_n low, asynchronous) clears the bitmap and count and sets capacity to 16.
// A write on cfg_we sets the initial capacity and reinitializes the allocator.
// Depends on bba_pkg.
`default_nettype none

module bitmap_block_allocator_unit #(
    parameter int MAX_SLOTS = bba_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [bba_pkg::FUNC_W-1:0]   func,
    input  wire logic [bba_pkg::INDEX_W-1:0]  block_index,
    input  wire logic                         cfg_we,
    input  wire logic [bba_pkg::CFG_W-1:0]    cfg_data,
    output logic                              done,
    output logic [bba_pkg::STATUS_W-1:0]      status,
    output logic [bba_pkg::INDEX_W-1:0]       slot,
    output logic [bba_pkg::COUNT_W-1:0]       used_count,
    output logic [bba_pkg::COUNT_W-1:0]       capacity,
    output logic [bba_pkg::COUNT_W-1:0]       longest_run
);
    import bba_pkg::*;

    localparam int SLOT_IW   = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int HALF      = MAX_SLOTS / 2;
    localparam int SPLIT     = CNT_W / 2;
    localparam int RESET_EFF = (INIT_RESET > HALF) ? HALF : INIT_RESET;

    typedef logic [MAX_SLOTS-1:0] vec_t;

    function automatic vec_t low_mask(input logic [CNT_W-1:0] n);
        vec_t m;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    function automatic logic [SLOT_IW-1:0] lowest(input vec_t v);
        logic [SLOT_IW-1:0] r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SLOT_IW'(i);
            end
        end
        return r;
    endfunction

    // starts of runs of at least 2**b ones
    function automatic vec_t run_pat(input vec_t x, input int b);
        vec_t p;
        p = x;
        for (int k = 0; k < CNT_W - 1; k++)
        begin
            if (k < b)
            begin
                p = p & (p >> (1 << k));
            end
        end
        return p;
    endfunction

    // allocator state
    vec_t             occ_reg,   occ_next;
    logic [CNT_W-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] max_reg;
    logic [CNT_W-1:0] cfg_eff;

    // input register
    logic               s0_v_reg;
    func_t              s0_func_reg;
    logic [INDEX_W-1:0] s0_idx_reg;

    // stage 1
    status_t            st1;
    logic [SLOT_IW-1:0] slot1;
    logic               s1_v_reg;
    status_t            s1_status_reg;
    logic [SLOT_IW-1:0] s1_slot_reg;
    logic [CNT_W-1:0]   s1_count_reg;
    logic [CNT_W-1:0]   s1_cap_reg;
    vec_t               s1_x_reg;

    // stage 2
    vec_t               cur2;
    logic [CNT_W-1:0]   len2;
    logic               s2_v_reg;
    status_t            s2_status_reg;
    logic [SLOT_IW-1:0] s2_slot_reg;
    logic [CNT_W-1:0]   s2_count_reg;
    logic [CNT_W-1:0]   s2_cap_reg;
    vec_t               s2_x_reg;
    vec_t               s2_cur_reg;
    logic [CNT_W-1:0]   s2_len_reg;

    // stage 3 / output
    logic [CNT_W-1:0]   len3;
    logic               done_reg;
    status_t            out_status_reg;
    logic [SLOT_IW-1:0] out_slot_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic [CNT_W-1:0]   out_cap_reg;
    logic [CNT_W-1:0]   out_run_reg;

    assign busy = 1'b0;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_eff = CNT_W'(1);
        end
        else if (int'(cfg_data) > HALF)
        begin
            cfg_eff = CNT_W'(HALF);
        end
        else
        begin
            cfg_eff = CNT_W'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s0_func_reg <= func_t'(func);
            s0_idx_reg  <= block_index;
        end
    end

    // stage 1: apply the operation
    always_comb
    begin
        vec_t               mask_lim;
        vec_t               free_lim;
        vec_t               free_max;
        vec_t               used_lim;
        logic               in_range;
        logic [SLOT_IW-1:0] idx_b;
        logic               lim_at_max;

        mask_lim   = low_mask(limit_reg);
        free_lim   = ~occ_reg & mask_lim;
        free_max   = ~occ_reg & low_mask(max_reg);
        used_lim   = occ_reg & mask_lim;
        in_range   = int'(s0_idx_reg) < int'(max_reg);
        idx_b      = s0_idx_reg[SLOT_IW-1:0];
        lim_at_max = (limit_reg == max_reg);

        occ_next   = occ_reg;
        limit_next = limit_reg;
        count_next = count_reg;
        st1        = ST_OK;
        slot1      = '0;

        case (s0_func_reg)
            FN_ALLOC_NAMED:
            begin
                if (!in_range)
                begin
                    st1 = ST_RANGE;
                end
                else
                begin
                    if (int'(s0_idx_reg) >= int'(limit_reg))
                    begin
                        limit_next = max_reg;
                    end
                    if (occ_reg[idx_b])
                    begin
                        st1 = ST_INUSE;
                    end
                    else
                    begin
                        occ_next[idx_b] = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                        slot1           = idx_b;
                    end
                end
            end
            FN_ALLOC_FIRST:
            begin
                if (|free_lim)
                begin
                    occ_next[lowest(free_lim)] = 1'b1;
                    count_next                 = count_reg + CNT_W'(1);
                    slot1                      = lowest(free_lim);
                end
                else if (lim_at_max)
                begin
                    st1 = ST_NOFREE;
                end
                else
                begin
                    limit_next = max_reg;
                    if (|free_max)
                    begin
                        occ_next[lowest(free_max)] = 1'b1;
                        count_next                 = count_reg + CNT_W'(1);
                        slot1                      = lowest(free_max);
                    end
                    else
                    begin
                        st1 = ST_NOFREE;
                    end
                end
            end
            FN_FREE_NAMED:
            begin
                if (!in_range)
                begin
                    st1 = ST_RANGE;
                end
                else if (!occ_reg[idx_b])
                begin
                    st1 = ST_NONE;
                end
                else
                begin
                    occ_next[idx_b] = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    slot1           = idx_b;
                end
            end
            FN_FREE_LOWEST:
            begin
                if (|used_lim)
                begin
                    occ_next[lowest(used_lim)] = 1'b0;
                    count_next                 = count_reg - CNT_W'(1);
                    slot1                      = lowest(used_lim);
                end
                else
                begin
                    st1 = ST_NONE;
                end
            end
            default:
            begin
                st1 = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
            limit_reg <= CNT_W'(RESET_EFF);
            max_reg   <= CNT_W'(2 * RESET_EFF);
            s1_v_reg  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s0_v_reg;
            if (cfg_we)
            begin
                occ_reg   <= '0;
                count_reg <= '0;
                limit_reg <= cfg_eff;
                max_reg   <= CNT_W'({cfg_eff, 1'b0});
            end
            else if (s0_v_reg)
            begin
                occ_reg   <= occ_next;
                count_reg <= count_next;
                limit_reg <= limit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_v_reg)
        begin
            s1_status_reg <= st1;
            s1_slot_reg   <= slot1;
            s1_count_reg  <= count_next;
            s1_cap_reg    <= limit_next;
            s1_x_reg      <= occ_next & low_mask(limit_next);
        end
    end

    // stage 2: longest run, upper length bits
    always_comb
    begin
        vec_t pat;
        vec_t cand;
        cur2 = '0;
        len2 = '0;
        for (int b = CNT_W - 1; b >= SPLIT; b--)
        begin
            pat  = run_pat(s1_x_reg, b);
            cand = (len2 == '0) ? pat : (pat & (cur2 >> (1 << b)));
            if (|cand)
            begin
                cur2 = cand;
                len2 = len2 | CNT_W'(1 << b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_v_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_slot_reg   <= s1_slot_reg;
            s2_count_reg  <= s1_count_reg;
            s2_cap_reg    <= s1_cap_reg;
            s2_x_reg      <= s1_x_reg;
            s2_cur_reg    <= cur2;
            s2_len_reg    <= len2;
        end
    end

    // stage 3: longest run, lower length bits
    always_comb
    begin
        vec_t cur;
        vec_t pat;
        vec_t cand;
        cur  = s2_cur_reg;
        len3 = s2_len_reg;
        for (int b = SPLIT - 1; b >= 0; b--)
        begin
            pat  = run_pat(s2_x_reg, b);
            cand = (len3 == '0) ? pat : (pat & (cur >> (1 << b)));
            if (|cand)
            begin
                cur  = cand;
                len3 = len3 | CNT_W'(1 << b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
        begin
            out_status_reg <= s2_status_reg;
            out_slot_reg   <= s2_slot_reg;
            out_count_reg  <= s2_count_reg;
            out_cap_reg    <= s2_cap_reg;
            out_run_reg    <= len3;
        end
    end

    assign done        = done_reg;
    assign status      = out_status_reg;
    assign slot        = INDEX_W'(out_slot_reg);
    assign used_count  = COUNT_W'(out_count_reg);
    assign capacity    = COUNT_W'(out_cap_reg);
    assign longest_run = COUNT_W'(out_run_reg);

endmodule

`default_nettype wire

// ===== design/bba_checker.sv =====
// Port-level checker for bitmap_block_allocator_unit, attached by bind.
// Depends on bba_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bba_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic [bba_pkg::STATUS_W-1:0] status,
    input wire logic [bba_pkg::INDEX_W-1:0]  slot,
    input wire logic [bba_pkg::COUNT_W-1:0]  used_count,
    input wire logic [bba_pkg::COUNT_W-1:0]  capacity,
    input wire logic [bba_pkg::COUNT_W-1:0]  longest_run
);
    import bba_pkg::*;

    // every accepted item yields its result on done
    `CHK_DELAY(a_item_latency, start && !busy, 4, done)
    // no result without an earlier accepted item
    `CHK_IMPL(a_no_spurious, done, $past(start && !busy, 4))
    `CHK_IMPL(a_slot_zero_on_err, done && (status != ST_OK), slot == '0)
    `CHK_IMPL(a_count_bounds, done, (longest_run <= used_count) && (used_count <= capacity))

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for bitmap_block_allocator_unit: directed table, then random phases.
// Results are checked in order against the table's expected values or an in-bench allocator model.
// Depends on bba_pkg and the top level only.
module testbench;
    import bba_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_GAP   = 6;

    typedef struct packed {
        status_t              st;
        logic [INDEX_W-1:0]   slot;
        logic [COUNT_W-1:0]   used;
        logic [COUNT_W-1:0]   cap;
        logic [COUNT_W-1:0]   run;
    } alloc_result_t;

    typedef struct {
        bit                 is_cfg;
        logic [CFG_W-1:0]   cfg_val;
        func_t              op;
        logic [INDEX_W-1:0] idx;
        bit                 typed;
        alloc_result_t      res;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [FUNC_W-1:0]   func;
    logic [INDEX_W-1:0]  block_index;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_data;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  slot;
    logic [COUNT_W-1:0]  used_count;
    logic [COUNT_W-1:0]  capacity;
    logic [COUNT_W-1:0]  longest_run;

    bit            row_typed;
    alloc_result_t row_exp;
    bit            burst;

    // allocator model state
    logic [CFG_W-1:0] init_reg;
    logic [63:0]      bitmap_q;
    int               cap_lim;

    alloc_result_t pending_results[$];
    stim_row_t     stim_table[$];
    int            err_count;
    int            cycles;

    bitmap_block_allocator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .block_index (block_index),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .used_count  (used_count),
        .capacity    (capacity),
        .longest_run (longest_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int base_capacity();
        int v;
        v = init_reg;
        if (v < 1)
            v = 1;
        if (v > MAX_SLOTS_DEF / 2)
            v = MAX_SLOTS_DEF / 2;
        return v;
    endfunction

    function automatic logic [63:0] mask_below(int n);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < n && i < 64; i++)
            m[i] = 1'b1;
        return m;
    endfunction

    function automatic int first_one(logic [63:0] v);
        for (int i = 0; i < 64; i++)
            if (v[i])
                return i;
        return 64;
    endfunction

    function automatic int longest_used_run();
        int cur;
        int best;
        cur = 0;
        best = 0;
        for (int i = 0; i < cap_lim && i < 64; i++)
        begin
            if (bitmap_q[i])
            begin
                cur++;
                if (cur > best)
                    best = cur;
            end
            else
                cur = 0;
        end
        return best;
    endfunction

    function automatic alloc_result_t apply_op(func_t op, logic [INDEX_W-1:0] idx);
        alloc_result_t r;
        int top;
        int pos;
        top = 2 * base_capacity();
        r.st = ST_OK;
        pos = 0;
        case (op)
            FN_ALLOC_NAMED:
            begin
                if (idx >= top)
                    r.st = ST_RANGE;
                else
                begin
                    if (idx >= cap_lim)
                        cap_lim = top;
                    if (bitmap_q[idx])
                        r.st = ST_INUSE;
                    else
                        pos = idx;
                end
            end
            FN_ALLOC_FIRST:
            begin
                pos = first_one(~bitmap_q & mask_below(cap_lim));
                if (pos >= cap_lim)
                begin
                    if (cap_lim >= top)
                        r.st = ST_NOFREE;
                    else
                    begin
                        cap_lim = top;
                        pos = first_one(~bitmap_q & mask_below(cap_lim));
                        if (pos >= cap_lim)
                            r.st = ST_NOFREE;
                    end
                end
            end
            FN_FREE_NAMED:
            begin
                if (idx >= top)
                    r.st = ST_RANGE;
                else if (!bitmap_q[idx])
                    r.st = ST_NONE;
                else
                    pos = idx;
            end
            default:
            begin
                pos = first_one(bitmap_q & mask_below(cap_lim));
                if (pos >= cap_lim)
                    r.st = ST_NONE;
            end
        endcase
        if (r.st == ST_OK)
            bitmap_q[pos] = (op == FN_ALLOC_NAMED || op == FN_ALLOC_FIRST);
        else
            pos = 0;
        r.slot = pos[INDEX_W-1:0];
        r.used = COUNT_W'($countones(bitmap_q));
        r.cap  = cap_lim[COUNT_W-1:0];
        r.run  = COUNT_W'(longest_used_run());
        return r;
    endfunction

    // scoreboard and model update, all on the rising edge
    always @(posedge clk)
    begin
        alloc_result_t e;
        alloc_result_t p;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with nothing expected: status %0d slot %0d", status, slot);
                    err_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (status !== e.st)
                    begin
                        $error("status: expected %0d, got %0d", e.st, status);
                        err_count++;
                    end
                    if (slot !== e.slot)
                    begin
                        $error("slot: expected %0d, got %0d", e.slot, slot);
                        err_count++;
                    end
                    if (used_count !== e.used)
                    begin
                        $error("used_count: expected %0d, got %0d", e.used, used_count);
                        err_count++;
                    end
                    if (capacity !== e.cap)
                    begin
                        $error("capacity: expected %0d, got %0d", e.cap, capacity);
                        err_count++;
                    end
                    if (longest_run !== e.run)
                    begin
                        $error("longest_run: expected %0d, got %0d", e.run, longest_run);
                        err_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                init_reg = cfg_data;
                bitmap_q = '0;
                cap_lim = base_capacity();
            end
            if (start && !busy)
            begin
                p = apply_op(func_t'(func), block_index);
                pending_results.push_back(row_typed ? row_exp : p);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(input func_t op, input logic [INDEX_W-1:0] idx,
                             input bit typed, input alloc_result_t e);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       <= 1'b1;
        func        <= op;
        block_index <= idx;
        row_typed   <= typed;
        row_exp     <= e;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_W-1:0] v);
        drain();
        repeat (DRAIN_GAP) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic stim_row_t op_row(func_t op, int idx, bit typed = 1'b0,
                                         status_t st = ST_OK, int sl = 0, int used = 0,
                                         int cap = 0, int run = 0);
        stim_row_t r;
        r.is_cfg   = 1'b0;
        r.cfg_val  = '0;
        r.op       = op;
        r.idx      = INDEX_W'(idx);
        r.typed    = typed;
        r.res.st   = st;
        r.res.slot = INDEX_W'(sl);
        r.res.used = COUNT_W'(used);
        r.res.cap  = COUNT_W'(cap);
        r.res.run  = COUNT_W'(run);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(int v);
        stim_row_t r;
        r = op_row(FN_ALLOC_NAMED, 0);
        r.is_cfg  = 1'b1;
        r.cfg_val = CFG_W'(v);
        return r;
    endfunction

    initial
    begin
        int phase_cfg[8];
        bit fill;
        int roll;
        int top;
        func_t op;
        logic [INDEX_W-1:0] idx;
        alloc_result_t none_res;

        rst_n       = 1'b0;
        start       = 1'b0;
        func        = '0;
        block_index = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        row_typed   = 1'b0;
        row_exp     = '0;
        burst       = 1'b0;
        none_res    = '0;
        init_reg    = CFG_W'(INIT_RESET);
        bitmap_q    = '0;
        cap_lim     = INIT_RESET;
        err_count   = 0;
        cycles      = 0;

        // reset capacity 16, maximum 32
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0, 1, ST_NONE, 0, 0, 16, 0));
        stim_table.push_back(op_row(FN_FREE_NAMED, 63, 1, ST_RANGE, 0, 0, 16, 0));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 32, 1, ST_RANGE, 0, 0, 16, 0));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 0, 1, ST_OK, 0, 1, 16, 1));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 0, 1, ST_INUSE, 0, 1, 16, 1));
        stim_table.push_back(op_row(FN_ALLOC_FIRST, 63, 1, ST_OK, 1, 2, 16, 2));
        stim_table.push_back(op_row(FN_FREE_NAMED, 5, 1, ST_NONE, 0, 2, 16, 2));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 31, 1, ST_OK, 31, 3, 32, 2));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 31, 1, ST_INUSE, 0, 3, 32, 2));
        stim_table.push_back(op_row(FN_FREE_NAMED, 31, 1, ST_OK, 31, 2, 32, 2));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 45));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0, 1, ST_OK, 1, 0, 32, 0));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0, 1, ST_NONE, 0, 0, 32, 0));
        // zero acts as one: capacity 1, maximum 2
        stim_table.push_back(cfg_row(0));
        stim_table.push_back(op_row(FN_ALLOC_FIRST, 0, 1, ST_OK, 0, 1, 1, 1));
        stim_table.push_back(op_row(FN_ALLOC_FIRST, 0, 1, ST_OK, 1, 2, 2, 2));
        stim_table.push_back(op_row(FN_ALLOC_FIRST, 0, 1, ST_NOFREE, 0, 2, 2, 2));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 2, 1, ST_RANGE, 0, 2, 2, 2));
        stim_table.push_back(op_row(FN_FREE_NAMED, 63, 1, ST_RANGE, 0, 2, 2, 2));
        stim_table.push_back(op_row(FN_FREE_NAMED, 1, 1, ST_OK, 1, 1, 2, 1));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0));
        // oversize clamps to 32: maximum 64
        stim_table.push_back(cfg_row(63));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 63, 1, ST_OK, 63, 1, 64, 1));
        stim_table.push_back(op_row(FN_ALLOC_NAMED, 0));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0));
        stim_table.push_back(op_row(FN_FREE_LOWEST, 0, 1, ST_OK, 63, 0, 64, 0));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
                write_cfg(stim_table[i].cfg_val);
            else
                send_item(stim_table[i].op, stim_table[i].idx, stim_table[i].typed,
                          stim_table[i].res);
        end

        phase_cfg = '{1, 32, 63, 0, $urandom_range(0, 63), 16, $urandom_range(0, 63), 2};
        fill = 1'($urandom_range(0, 1));
        foreach (phase_cfg[ph])
        begin
            write_cfg(CFG_W'(phase_cfg[ph]));
            top = 2 * base_capacity();
            for (int n = 0; n < 150; n++)
            begin
                if (n % 50 == 0)
                begin
                    burst = ($urandom_range(0, 3) == 0);
                    fill = ~fill;
                end
                if (n == 75 && (ph == 0 || $urandom_range(0, 2) == 0))
                    drain();
                roll = $urandom_range(0, 99);
                if (fill)
                    op = roll < 40 ? FN_ALLOC_NAMED : roll < 80 ? FN_ALLOC_FIRST :
                         roll < 90 ? FN_FREE_NAMED : FN_FREE_LOWEST;
                else
                    op = roll < 40 ? FN_FREE_NAMED : roll < 80 ? FN_FREE_LOWEST :
                         roll < 90 ? FN_ALLOC_NAMED : FN_ALLOC_FIRST;
                if ($urandom_range(0, 9) == 0)
                    idx = INDEX_W'($urandom_range(0, 63));
                else
                    idx = INDEX_W'($urandom_range(0, top - 1));
                send_item(op, idx, 1'b0, none_res);
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (err_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
